// ===== src/assert_macros.svh =====
// Shared assertion macros for the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mre_pkg.sv =====
`timescale 1ns / 1ps

package mre_pkg;

    // Instruction forms
    localparam logic [1:0] KIND_REG_REG = 2'd0;
    localparam logic [1:0] KIND_REG_MEM = 2'd1;
    localparam logic [1:0] KIND_EXT_REG = 2'd2;
    localparam logic [1:0] KIND_EXT_MEM = 2'd3;

    // Operand size codes
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;
    localparam logic [1:0] SIZE_QWORD = 2'd3;

    // ModRM mod field
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP32  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;

    localparam logic [2:0] RM_SIB_BASE  = 3'd4;
    localparam logic [2:0] RM_BP_BASE   = 3'd5;

    localparam logic [7:0] PFX_OPSIZE   = 8'h66;
    localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
    localparam logic [7:0] REX_PLAIN    = 8'h40;
    localparam logic [7:0] REX_BIT_B    = 8'h41;
    localparam logic [7:0] REX_BIT_R    = 8'h44;
    localparam logic [7:0] REX_BIT_W    = 8'h48;
    localparam logic [7:0] ESCAPE_BYTE  = 8'h0f;
    localparam logic [7:0] SIB_NO_INDEX = 8'h24;

    // Byte slots in encoding order
    localparam int NUM_SLOTS    = 11;
    localparam int SLOT_OPSIZE  = 0;
    localparam int SLOT_ADDR    = 1;
    localparam int SLOT_REX     = 2;
    localparam int SLOT_ESCAPE  = 3;
    localparam int SLOT_OPCODE  = 4;
    localparam int SLOT_MODRM   = 5;
    localparam int SLOT_SIB     = 6;
    localparam int SLOT_DISP0   = 7;
    localparam int SLOT_DISP1   = 8;
    localparam int SLOT_DISP2   = 9;
    localparam int SLOT_DISP3   = 10;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         kind;
        logic [8:0]         opcode;
        logic [2:0]         reg_number;
        logic               reg_high;
        logic               reg_uniform_byte;
        logic [1:0]         operand_size;
        logic [2:0]         rm_number;
        logic               rm_high;
        logic               rm_uniform_byte;
        logic               base_is_32bit;
        logic signed [31:0] displacement;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } out_item_t;

    // Classified instruction: which slots are present plus the variable bytes
    typedef struct packed {
        logic [NUM_SLOTS-1:0] present;
        logic [7:0]           rex;
        logic [7:0]           opcode_lo;
        logic [7:0]           modrm;
        logic [31:0]          disp;
    } plan_t;

endpackage

// ===== src/mre_front.sv =====
`timescale 1ns / 1ps

module mre_front (
    input  mre_pkg::in_item_t item,
    output mre_pkg::plan_t    plan
);
    import mre_pkg::*;

    logic       memory;
    logic       ext;
    logic       small_disp;
    logic [1:0] mod_sel;
    logic [7:0] rex;

    always_comb
    begin
        memory = item.kind inside {KIND_REG_MEM, KIND_EXT_MEM};
        ext    = item.kind inside {KIND_EXT_REG, KIND_EXT_MEM};

        rex = 8'h00;
        if ((!ext && item.reg_uniform_byte) || (!memory && item.rm_uniform_byte))
            rex = rex | REX_PLAIN;
        if (item.operand_size == SIZE_QWORD)
            rex = rex | REX_BIT_W;
        if (!ext && item.reg_high)
            rex = rex | REX_BIT_R;
        if (item.rm_high)
            rex = rex | REX_BIT_B;

        // disp8 range is -126..127 here
        small_disp = (item.displacement >= -32'sd126) && (item.displacement <= 32'sd127);
        if (item.displacement == 32'sd0)
            mod_sel = (item.rm_number == RM_BP_BASE) ? MOD_DISP8 : MOD_NO_DISP;
        else if (small_disp)
            mod_sel = MOD_DISP8;
        else
            mod_sel = MOD_DISP32;
        if (!memory)
            mod_sel = MOD_REG;

        plan.present              = '0;
        plan.present[SLOT_OPSIZE] = (item.operand_size == SIZE_WORD);
        plan.present[SLOT_ADDR]   = memory && item.base_is_32bit;
        plan.present[SLOT_REX]    = (rex != 8'h00);
        plan.present[SLOT_ESCAPE] = item.opcode[8];
        plan.present[SLOT_OPCODE] = 1'b1;
        plan.present[SLOT_MODRM]  = 1'b1;
        plan.present[SLOT_SIB]    = memory && (item.rm_number == RM_SIB_BASE);
        plan.present[SLOT_DISP0]  = (mod_sel == MOD_DISP8) || (mod_sel == MOD_DISP32);
        plan.present[SLOT_DISP1]  = (mod_sel == MOD_DISP32);
        plan.present[SLOT_DISP2]  = (mod_sel == MOD_DISP32);
        plan.present[SLOT_DISP3]  = (mod_sel == MOD_DISP32);

        plan.rex       = rex;
        plan.opcode_lo = item.opcode[7:0];
        plan.modrm     = {mod_sel, item.reg_number, item.rm_number};
        plan.disp      = item.displacement;
    end

endmodule

// ===== src/mre_queue.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mre_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mre_pkg::plan_t push_plan,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mre_pkg::plan_t head_plan
);
    import mre_pkg::*;

    plan_t                  slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_plan  = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_plan;
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, head_valid, "pop from empty queue")
    `ASSERT_NEXT(a_push_lands, clk, rst_n, do_push && !do_pop, head_valid, "pushed request vanished")

endmodule

// ===== src/mre_back.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mre_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mre_pkg::plan_t      head_plan,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output mre_pkg::out_item_t  out_item
);
    import mre_pkg::*;

    logic [NUM_SLOTS-1:0] sent_reg;
    logic [NUM_SLOTS-1:0] sent_next;
    logic [NUM_SLOTS-1:0] remaining;
    logic [NUM_SLOTS-1:0] pick;
    logic [7:0]           slot_byte [NUM_SLOTS];
    logic [7:0]           sel_byte;
    logic                 sel_last;
    logic                 emit;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_item_reg;

    always_comb
    begin
        slot_byte[SLOT_OPSIZE] = PFX_OPSIZE;
        slot_byte[SLOT_ADDR]   = PFX_ADDRSIZE;
        slot_byte[SLOT_REX]    = head_plan.rex;
        slot_byte[SLOT_ESCAPE] = ESCAPE_BYTE;
        slot_byte[SLOT_OPCODE] = head_plan.opcode_lo;
        slot_byte[SLOT_MODRM]  = head_plan.modrm;
        slot_byte[SLOT_SIB]    = SIB_NO_INDEX;
        slot_byte[SLOT_DISP0]  = head_plan.disp[7:0];
        slot_byte[SLOT_DISP1]  = head_plan.disp[15:8];
        slot_byte[SLOT_DISP2]  = head_plan.disp[23:16];
        slot_byte[SLOT_DISP3]  = head_plan.disp[31:24];
    end

    // next byte to send is the lowest present slot not yet sent
    assign remaining = head_plan.present & ~sent_reg;
    assign pick      = remaining & (~remaining + 1'b1);
    assign sel_last  = ((remaining & ~pick) == '0);

    always_comb
    begin
        sel_byte = 8'h00;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (pick[i])
                sel_byte = sel_byte | slot_byte[i];
        end
    end

    assign emit = head_valid && (!out_valid_reg || out_ready);
    assign pop  = emit && sel_last;

    always_comb
    begin
        sent_next = sent_reg;
        if (emit)
            sent_next = sel_last ? '0 : (sent_reg | pick);

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg.code_byte <= sel_byte;
            out_item_reg.last_byte <= sel_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `ASSERT_IMPLIES(a_head_has_bytes, clk, rst_n, head_valid, remaining != '0, "request with nothing left to send")
    `ASSERT_ALWAYS(a_pick_onehot, clk, rst_n, $onehot0(pick), "more than one slot picked")
    `ASSERT_IMPLIES(a_idle_clean, clk, rst_n, !head_valid, sent_reg == '0, "stale sent mask without a request")

endmodule

// ===== src/x86_64_modrm_instruction_encoder_top.sv =====
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// in       in_valid / in_ready     in_item  (mre_pkg::in_item_t), one instruction
// out      out_valid / out_ready   out_item (mre_pkg::out_item_t), one code byte
//
// One output byte per cycle while out_ready is high; an instruction has 2 to 11 bytes.
// The byte stepper in the back end sets the rate; the front classifies in the accept cycle.
// A two-entry queue lets new requests enter while earlier ones are still being sent.
// An accepted request is first written into the queue; its first byte is then registered onto out.
// in_ready drops while the queue holds two requests; out_ready low with out_valid high freezes the stepper.
// rst_n is asynchronous; it clears the queue, the byte mask and out_valid.

module x86_64_modrm_instruction_encoder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mre_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output mre_pkg::out_item_t out_item
);
    import mre_pkg::*;

    plan_t front_plan;
    plan_t head_plan;
    logic  queue_full;
    logic  head_valid;
    logic  pop;

    mre_front u_front (
        .item (in_item),
        .plan (front_plan)
    );

    mre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_plan  (front_plan),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_plan  (head_plan)
    );

    mre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_plan  (head_plan),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    assign in_ready = !queue_full;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mre_pkg::*;

    localparam int RANDOM_ITEMS    = 400;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 4000;

    class code_byte_tracker;
        out_item_t expected_bytes[$];
        int        mismatch_count;

        function int outstanding();
            return expected_bytes.size();
        endfunction

        // Encodes one request into the byte sequence it should produce.
        function void note_request(in_item_t req);
            logic [7:0]  encoding[$];
            logic [7:0]  rex;
            logic [1:0]  mod_field;
            logic [31:0] disp;
            logic        is_memory;
            logic        is_ext;
            logic        short_disp;
            out_item_t   b;

            is_memory = (req.kind == KIND_REG_MEM) || (req.kind == KIND_EXT_MEM);
            is_ext    = (req.kind == KIND_EXT_REG) || (req.kind == KIND_EXT_MEM);
            disp      = req.displacement;
            rex       = 8'h00;

            if (req.operand_size == SIZE_WORD)
                encoding.push_back(PFX_OPSIZE);
            if (is_memory && req.base_is_32bit)
                encoding.push_back(PFX_ADDRSIZE);

            if (!is_ext && req.reg_uniform_byte)
                rex |= REX_PLAIN;
            if (!is_memory && req.rm_uniform_byte)
                rex |= REX_PLAIN;
            if (req.operand_size == SIZE_QWORD)
                rex |= REX_BIT_W;
            if (!is_ext && req.reg_high)
                rex |= REX_BIT_R;
            if (req.rm_high)
                rex |= REX_BIT_B;
            if (rex != 8'h00)
                encoding.push_back(rex);

            if (req.opcode[8])
                encoding.push_back(ESCAPE_BYTE);
            encoding.push_back(req.opcode[7:0]);

            if (!is_memory)
            begin
                encoding.push_back({MOD_REG, req.reg_number, req.rm_number});
            end
            else
            begin
                // disp8 covers -126..127 only
                short_disp = disp[31] ? (disp >= 32'hffffff82) : (disp <= 32'd127);
                if (disp == 32'd0)
                    mod_field = MOD_NO_DISP;
                else if (short_disp)
                    mod_field = MOD_DISP8;
                else
                    mod_field = MOD_DISP32;
                // rbp/r13 base has no disp-less form
                if (mod_field == MOD_NO_DISP && req.rm_number == RM_BP_BASE)
                    mod_field = MOD_DISP8;
                encoding.push_back({mod_field, req.reg_number, req.rm_number});
                if (req.rm_number == RM_SIB_BASE)
                    encoding.push_back(SIB_NO_INDEX);
                if (mod_field == MOD_DISP8)
                begin
                    encoding.push_back(disp[7:0]);
                end
                else if (mod_field == MOD_DISP32)
                begin
                    encoding.push_back(disp[7:0]);
                    encoding.push_back(disp[15:8]);
                    encoding.push_back(disp[23:16]);
                    encoding.push_back(disp[31:24]);
                end
            end

            foreach (encoding[i])
            begin
                b.code_byte = encoding[i];
                b.last_byte = (i == encoding.size() - 1);
                expected_bytes.push_back(b);
            end
        endfunction

        function void check_byte(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: code_byte expected none, actual %h (last_byte %b)",
                         $time, got.code_byte, got.last_byte);
                mismatch_count++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.code_byte !== want.code_byte)
            begin
                $display("%0t: code_byte expected %h, actual %h",
                         $time, want.code_byte, got.code_byte);
                mismatch_count++;
            end
            if (got.last_byte !== want.last_byte)
            begin
                $display("%0t: last_byte expected %b, actual %b",
                         $time, want.last_byte, got.last_byte);
                mismatch_count++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    code_byte_tracker tracker = new();
    logic             no_idle = 1'b0;
    logic             hold_off_pending = 1'b0;
    int               quiet_cycles = 0;

    x86_64_modrm_instruction_encoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_request(in_item);
            if (out_valid && out_ready)
                tracker.check_byte(out_item);
        end
    end

    // Nothing moving on either channel for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("x86_64_modrm_instruction_encoder_top verification failed");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_pending = 1'b0;
            end
            else
            begin
                out_ready <= no_idle || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    function automatic in_item_t plain_request(logic [1:0] kind, logic [8:0] opcode);
        in_item_t r;
        r        = '0;
        r.kind   = kind;
        r.opcode = opcode;
        return r;
    endfunction

    function automatic in_item_t random_request();
        in_item_t    r;
        logic [63:0] bits;
        int          near_limits[7] = '{-128, -127, -126, -1, 1, 127, 128};
        bits = {$urandom, $urandom};
        r    = bits[$bits(in_item_t)-1:0];
        case ($urandom_range(0, 9))
            0, 1:    r.displacement = 0;
            2, 3, 4: r.displacement = int'($urandom_range(0, 260)) - 130;
            5:       r.displacement = near_limits[$urandom_range(0, 6)];
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input in_item_t req);
        if (!no_idle && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        in_item_t r;
        int       disp_points[8];

        disp_points = '{1, 127, 128, -1, -126, -127, -128, 32'h7fffffff};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(plain_request(KIND_REG_REG, 9'h000));

        // every flag set on a register form; memory-only fields must not matter
        r = plain_request(KIND_REG_REG, 9'h1ff);
        r.reg_number       = 3'd7;
        r.rm_number        = 3'd7;
        r.reg_high         = 1'b1;
        r.rm_high          = 1'b1;
        r.reg_uniform_byte = 1'b1;
        r.rm_uniform_byte  = 1'b1;
        r.operand_size     = SIZE_QWORD;
        r.base_is_32bit    = 1'b1;
        r.displacement     = -1;
        send_request(r);

        r = plain_request(KIND_REG_MEM, 9'h100);
        r.operand_size  = SIZE_WORD;
        r.base_is_32bit = 1'b1;
        send_request(r);

        r = plain_request(KIND_EXT_MEM, 9'h0ff);
        r.rm_number = RM_BP_BASE;
        send_request(r);

        r = plain_request(KIND_REG_MEM, 9'h08b);
        r.rm_number = RM_SIB_BASE;
        send_request(r);

        // extension/memory ignores reg flags and rm uniform flag
        r = plain_request(KIND_EXT_MEM, 9'h1af);
        r.rm_number        = RM_SIB_BASE;
        r.reg_number       = 3'd6;
        r.reg_high         = 1'b1;
        r.reg_uniform_byte = 1'b1;
        r.rm_uniform_byte  = 1'b1;
        r.rm_high          = 1'b1;
        r.operand_size     = SIZE_QWORD;
        r.base_is_32bit    = 1'b1;
        r.displacement     = 32'h80000000;
        send_request(r);

        foreach (disp_points[i])
        begin
            r = plain_request(KIND_REG_MEM, 9'h089);
            r.rm_number    = i[2:0];
            r.reg_number   = 3'd7 - i[2:0];
            r.operand_size = SIZE_DWORD;
            r.displacement = disp_points[i];
            send_request(r);
        end

        r = plain_request(KIND_EXT_REG, 9'h0f7);
        r.reg_high         = 1'b1;
        r.reg_uniform_byte = 1'b1;
        r.operand_size     = SIZE_DWORD;
        send_request(r);

        r = plain_request(KIND_EXT_REG, 9'h0d1);
        r.rm_uniform_byte = 1'b1;
        r.operand_size    = SIZE_WORD;
        send_request(r);

        r = plain_request(KIND_REG_REG, 9'h088);
        r.reg_uniform_byte = 1'b1;
        r.reg_number       = 3'd6;
        r.operand_size     = SIZE_DWORD;
        send_request(r);

        wait_for_drain();

        no_idle = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 120)
                no_idle = 1'b0;
            if (n == 200)
                hold_off_pending = 1'b1;
            if (n == 300)
                wait_for_drain();
            send_request(random_request());
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
            $display("x86_64_modrm_instruction_encoder_top verification clean");
        else
            $display("x86_64_modrm_instruction_encoder_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/mre_pkg.sv
src/mre_front.sv
src/mre_queue.sv
src/mre_back.sv
src/x86_64_modrm_instruction_encoder_top.sv
test/tb.sv
